// ===== rtl/bpc_pkg.sv =====
// Shared types, constants and register codes of the button press classifier.
package bpc_pkg;

   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int EVENT_W   = 2;
   localparam int CSR_IDX_W = 2;

   // press event codes
   localparam logic [EVENT_W-1:0] EV_SHORT = 2'd0;
   localparam logic [EVENT_W-1:0] EV_LONG  = 2'd1;
   localparam logic [EVENT_W-1:0] EV_HOLD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_INTERVAL = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RST    = 16'd1000;
   localparam logic [CFG_W-1:0] HOLD_INTERVAL_RST = 16'd200;

   typedef struct packed {
      logic              pin_level;
      logic [TIME_W-1:0] time_ms;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] long_press_ms;
      logic [CFG_W-1:0] hold_interval_ms;
   } cfg_type;

endpackage

// ===== rtl/bpc_channels.sv =====
// Valid/ready channel interfaces for pin samples and press events.
interface bpc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          pin_level;
   logic [bpc_pkg::TIME_W-1:0]    time_ms;

   modport source (output valid, output pin_level, output time_ms, input ready);
   modport sink   (input valid, input pin_level, input time_ms, output ready);
endinterface

interface bpc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpc_pkg::EVENT_W-1:0]   press_event;

   modport source (output valid, output press_event, input ready);
   modport sink   (input valid, input press_event, output ready);
endinterface

// ===== rtl/button_press_classifier.sv =====
// Top level of the button press classifier.
//
// Classifies presses of an active-low push button from timestamped samples.
// req_chan: one transfer per raw pin sample (pin_level, time_ms in ms, wraps).
// rsp_chan: zero or one transfer per sample carrying press_event:
//    EV_SHORT on release of a short press, EV_LONG on release after hold
//    mode, EV_HOLD repeating every hold interval while held.
// csr_*: write port for debounce, long-press and hold-interval times;
//    write only while no sample is in flight.
// Path: an accepted sample passes the input register, then the
//    classifier's result register, before its event is visible on rsp_chan.
// Throughput: one sample per cycle while rsp_chan does not stall; each
//    sample needs three 32-bit subtract/compare paths on the state registers.
// When rsp_chan stalls, the result register holds its event and the input
//    register still takes one more sample if empty; then req_chan.ready drops.
// Reset (synchronous, active high): pin state released, timers zero,
//    registers back to 50 / 1000 / 200 ms, both channels empty.
module button_press_classifier (
   input  logic                           clock,
   input  logic                           reset,
   bpc_req_if.sink                        req_chan,
   bpc_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpc_pkg::CFG_W-1:0]      csr_wdata
);

   bpc_pkg::cfg_type   cfg;
   bpc_pkg::item_type  req_item;
   bpc_pkg::stage_type stage;
   logic               advance;

   assign req_item.pin_level = req_chan.pin_level;
   assign req_item.time_ms   = req_chan.time_ms;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sample register
   bpc_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_item  (req_item),
      .advance   (advance),
      .req_ready (req_chan.ready),
      .stage     (stage)
   );

   // debounce, press tracking and event register
   bpc_classify u_classify (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .stage           (stage),
      .rsp_ready       (rsp_chan.ready),
      .advance         (advance),
      .rsp_valid       (rsp_chan.valid),
      .rsp_press_event (rsp_chan.press_event)
   );

endmodule

// ===== rtl/bpc_csr.sv =====
// Configuration registers of the button press classifier.
module bpc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpc_pkg::CFG_W-1:0]      csr_wdata,
   output bpc_pkg::cfg_type               cfg
);

   bpc_pkg::cfg_type cfg_ff;
   bpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bpc_pkg::CSR_DEBOUNCE:      cfg_in.debounce_ms      = csr_wdata;
            bpc_pkg::CSR_LONG_PRESS:    cfg_in.long_press_ms    = csr_wdata;
            bpc_pkg::CSR_HOLD_INTERVAL: cfg_in.hold_interval_ms = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= bpc_pkg::DEBOUNCE_RST;
         cfg_ff.long_press_ms    <= bpc_pkg::LONG_PRESS_RST;
         cfg_ff.hold_interval_ms <= bpc_pkg::HOLD_INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bpc_input_stage.sv =====
// Input register holding one accepted pin sample.
module bpc_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  bpc_pkg::item_type   req_item,
   input  logic                advance,
   output logic                req_ready,
   output bpc_pkg::stage_type  stage
);

   logic              valid_ff;
   logic              valid_in;
   bpc_pkg::item_type item_ff;
   logic              take;

   // free when empty or when the held sample moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// ===== rtl/bpc_classify.sv =====
// Debounce and press classification state with the result register.
module bpc_classify (
   input  logic                         clock,
   input  logic                         reset,
   input  bpc_pkg::cfg_type             cfg,
   input  bpc_pkg::stage_type           stage,
   input  logic                         rsp_ready,
   output logic                         advance,
   output logic                         rsp_valid,
   output logic [bpc_pkg::EVENT_W-1:0]  rsp_press_event
);

   localparam int TW = bpc_pkg::TIME_W;

   logic          stable_level_ff, stable_level_in;
   logic          previous_raw_ff, previous_raw_in;
   logic [TW-1:0] change_time_ff,  change_time_in;
   logic [TW-1:0] press_start_ff,  press_start_in;
   logic          is_pressed_ff,   is_pressed_in;
   logic          long_reached_ff, long_reached_in;
   logic          hold_mode_ff,    hold_mode_in;
   logic [TW-1:0] last_hold_ff,    last_hold_in;
   logic          rsp_valid_ff,    rsp_valid_in;
   logic [bpc_pkg::EVENT_W-1:0] event_ff, event_in;

   logic          fire;
   logic          raw;
   logic [TW-1:0] now;
   logic          changed;
   logic [TW-1:0] steady_time;
   logic [TW-1:0] dur;
   logic [TW-1:0] press_age;
   logic [TW-1:0] hold_age;
   logic          settle;
   logic          press;
   logic          release_hit;
   logic          reach_long;
   logic          hold_fire;
   logic          found;
   logic [bpc_pkg::EVENT_W-1:0] event_code;

   // the held sample moves on when the result slot is empty or draining
   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = stage.valid && advance;
   assign raw     = stage.item.pin_level;
   assign now     = stage.item.time_ms;

   // a fresh edge restarts the steady timer, so it cannot settle this sample
   assign changed     = raw != previous_raw_ff;
   assign steady_time = now - change_time_ff;
   assign settle      = !changed && (steady_time > TW'(cfg.debounce_ms))
                        && (raw != stable_level_ff);
   assign press       = settle && !raw;
   assign release_hit = settle && raw;

   assign dur       = now - press_start_ff;
   assign press_age = press ? '0 : dur;
   assign reach_long = (press || (is_pressed_ff && !release_hit))
                       && (press || !long_reached_ff)
                       && (press_age >= TW'(cfg.long_press_ms));

   assign hold_age  = now - last_hold_ff;

   always_comb begin
      stable_level_in = settle ? raw : stable_level_ff;
      change_time_in  = changed ? now : change_time_ff;
      press_start_in  = press ? now : press_start_ff;
      is_pressed_in   = is_pressed_ff;
      long_reached_in = long_reached_ff;
      hold_mode_in    = hold_mode_ff;
      if (press) begin
         is_pressed_in   = 1'b1;
         long_reached_in = 1'b0;
         hold_mode_in    = 1'b0;
      end else if (release_hit) begin
         is_pressed_in   = 1'b0;
         long_reached_in = 1'b0;
         hold_mode_in    = 1'b0;
      end
      if (reach_long) begin
         long_reached_in = 1'b1;
         hold_mode_in    = 1'b1;
      end
   end

   assign hold_fire    = hold_mode_in && (hold_age >= TW'(cfg.hold_interval_ms));
   assign last_hold_in = hold_fire ? now : last_hold_ff;

   // a hold repeat has priority, but a release clears hold mode, so the two never meet
   always_comb begin
      found      = 1'b0;
      event_code = bpc_pkg::EV_SHORT;
      priority if (hold_fire) begin
         found      = 1'b1;
         event_code = bpc_pkg::EV_HOLD;
      end else if (release_hit && hold_mode_ff) begin
         found      = 1'b1;
         event_code = bpc_pkg::EV_LONG;
      end else if (release_hit && !long_reached_ff && (dur < TW'(cfg.long_press_ms))) begin
         found      = 1'b1;
         event_code = bpc_pkg::EV_SHORT;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      event_in     = event_ff;
      if (fire) begin
         rsp_valid_in = found;
         event_in     = event_code;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff <= 1'b1;
         previous_raw_ff <= 1'b1;
         change_time_ff  <= '0;
         press_start_ff  <= '0;
         is_pressed_ff   <= 1'b0;
         long_reached_ff <= 1'b0;
         hold_mode_ff    <= 1'b0;
         last_hold_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            stable_level_ff <= stable_level_in;
            previous_raw_ff <= raw;
            change_time_ff  <= change_time_in;
            press_start_ff  <= press_start_in;
            is_pressed_ff   <= is_pressed_in;
            long_reached_ff <= long_reached_in;
            hold_mode_ff    <= hold_mode_in;
            last_hold_ff    <= last_hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_press_event = event_ff;

endmodule
